### sv/salc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and codes for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int AGE_W   = 3;
  localparam int WC_W    = 5;   // holds a way count of up to 16
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 6;
  localparam int CIDX_W  = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  localparam logic [CIDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WAYS     = 2'd2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
  } meta_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOK   = 4'b0100,
    ST_SECOND = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### sv/set_assoc_lru_cache_model.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache hit/miss model with true LRU ages and saturating totals.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one beat is an address and an opcode.
// Load and store give one result beat, modify gives two (last marks the end),
// opcode 3 is taken and gives nothing.
// Output channel (out_valid/out_stall): outcome plus the running totals.
// Steps: the beat is taken and the set row is read from the metadata and tag
// memories into registers; in ST_LOOK all ways are compared, the row is
// written back and the result is registered once the output can take it.
// A modify then does the same once more in ST_SECOND.
// The second access of a modify works on the row just written, held locally.
// A held result does not block the next input beat; the update waits while
// the output register is full and stalled.
// Reset clears the totals and restores the registers, then sweeps the
// metadata memory clean, one set per cycle, with in_stall high.
// Configuration writes go through at any time.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] address,
  input  logic [1:0]  opcode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic        last,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] eviction_total
);
  import salc_pkg::*;

  localparam int SETS = 1 << MAX_SET_BITS;

  typedef meta_t [MAX_WAYS-1:0]                  meta_row_t;
  typedef logic  [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_t;

  meta_row_t meta_mem [SETS];
  tag_row_t  tag_mem  [SETS];

  state_t                  state, state_next;
  logic [MAX_SET_BITS-1:0] clr_addr;
  logic [3:0]              set_index_bits;
  logic [5:0]              offset_bits;
  logic [3:0]              way_count;
  logic [WC_W-1:0]         ways_eff;

  logic [MAX_SET_BITS-1:0] split_set, cur_set;
  logic [ADDR_WIDTH-1:0]   split_tag, cur_tag;
  logic                    cur_modify;

  meta_row_t meta_rd, meta_hold, meta_src, meta_new;
  tag_row_t  tag_rd, tag_hold, tag_src, tag_new;
  outcome_t  upd_outcome, out_code;

  logic [TOTAL_W-1:0] hits, misses, evictions;
  logic               in_take, rd_go, go;

  salc_split #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_split (
    .address       (address),
    .set_index_bits(set_index_bits),
    .offset_bits   (offset_bits),
    .set           (split_set),
    .tag           (split_tag)
  );

  assign meta_src = (state == ST_SECOND) ? meta_hold : meta_rd;
  assign tag_src  = (state == ST_SECOND) ? tag_hold  : tag_rd;

  salc_update #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_update (
    .meta_row(meta_src),
    .tag_row (tag_src),
    .tag     (cur_tag),
    .ways    (ways_eff),
    .meta_new(meta_new),
    .tag_new (tag_new),
    .outcome (upd_outcome)
  );

  always_comb begin
    if (way_count == 4'd0) begin
      ways_eff = WC_W'(1);
    end else if ({1'b0, way_count} > WC_W'(MAX_WAYS)) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, way_count};
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && (state == ST_IDLE);
  assign rd_go    = in_take && (opcode != OP_NONE);
  assign go       = ((state == ST_LOOK) || (state == ST_SECOND)) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {MAX_SET_BITS{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (rd_go) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (go) state_next = cur_modify ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      set_index_bits <= 4'd4;
      offset_bits    <= 6'd4;
      way_count      <= 4'd1;
      out_valid      <= 1'b0;
      hits           <= '0;
      misses         <= '0;
      evictions      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + MAX_SET_BITS'(1);
      if (cfg_write) begin
        case (cfg_index)
          CFG_SET_BITS: set_index_bits <= cfg_data[3:0];
          CFG_OFF_BITS: offset_bits    <= cfg_data;
          CFG_WAYS:     way_count      <= cfg_data[3:0];
          default: ;
        endcase
      end
      out_valid <= go || (out_valid && out_stall);
      if (go) begin
        case (upd_outcome)
          OUT_HIT: begin
            if (hits != '1) hits <= hits + TOTAL_W'(1);
          end
          OUT_MISS: begin
            if (misses != '1) misses <= misses + TOTAL_W'(1);
          end
          default: begin
            if (misses != '1) misses <= misses + TOTAL_W'(1);
            if (evictions != '1) evictions <= evictions + TOTAL_W'(1);
          end
        endcase
      end
    end
  end

  // per-access payload
  always_ff @(posedge clk) begin
    if (rd_go) begin
      cur_set    <= split_set;
      cur_tag    <= split_tag;
      cur_modify <= (opcode == OP_MODIFY);
    end
    if (go) begin
      meta_hold <= meta_new;
      tag_hold  <= tag_new;
      out_code  <= upd_outcome;
      last      <= (state == ST_SECOND) || !cur_modify;
    end
  end

  // metadata memory: cleared after reset, written back after each access
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      meta_mem[clr_addr] <= '0;
    end else if (go) begin
      meta_mem[cur_set] <= meta_new;
    end
    if (rd_go) meta_rd <= meta_mem[split_set];
  end

  // tag memory: written back after each access; tags count only where the line is valid
  always_ff @(posedge clk) begin
    if (go) tag_mem[cur_set] <= tag_new;
    if (rd_go) tag_rd <= tag_mem[split_set];
  end

  assign outcome        = out_code;
  assign hit_total      = hits;
  assign miss_total     = misses;
  assign eviction_total = evictions;

endmodule
`default_nettype wire

### sv/salc_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_split
// Splits a byte address into set index and tag for the current geometry.
// ----------------------------------------------------------------------------
module salc_split #(
  parameter int MAX_SET_BITS = 10,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic [63:0]             address,
  input  logic [3:0]              set_index_bits,
  input  logic [5:0]              offset_bits,
  output logic [MAX_SET_BITS-1:0] set,
  output logic [ADDR_WIDTH-1:0]   tag
);
  import salc_pkg::*;

  logic [4:0]              sbits;
  logic [6:0]              tag_shift;
  logic [ADDR_WIDTH-1:0]   addr;
  logic [ADDR_WIDTH-1:0]   above_off;
  logic [MAX_SET_BITS-1:0] set_mask;

  always_comb begin
    sbits = ({1'b0, set_index_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                        : {1'b0, set_index_bits};
    addr      = address[ADDR_WIDTH-1:0];
    above_off = addr >> offset_bits;
    // shift amounts at or past the width give zero
    set_mask  = ~({MAX_SET_BITS{1'b1}} << sbits);
    set       = above_off[MAX_SET_BITS-1:0] & set_mask;
    tag_shift = {1'b0, offset_bits} + {2'b00, sbits};
    tag       = addr >> tag_shift;
  end

endmodule
`default_nettype wire

### sv/salc_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_update
// Lookup and LRU update of one set row: all ways compared in parallel.
// ----------------------------------------------------------------------------
module salc_update #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  salc_pkg::meta_t [MAX_WAYS-1:0]                  meta_row,
  input  logic            [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row,
  input  logic            [ADDR_WIDTH-1:0]                tag,
  input  logic            [salc_pkg::WC_W-1:0]            ways,
  output salc_pkg::meta_t [MAX_WAYS-1:0]                  meta_new,
  output logic            [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_new,
  output salc_pkg::outcome_t                              outcome
);
  import salc_pkg::*;

  logic [MAX_WAYS-1:0] in_use, live, hitv, freev;
  logic [MAX_WAYS-1:0] hit_oh, free_oh, vic_oh, target;
  logic                any_hit, any_free;
  logic [AGE_W-1:0]    ref_age;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = WC_W'(w) < ways;
      live[w]   = in_use[w] & meta_row[w].valid;
      hitv[w]   = live[w] && (tag_row[w] == tag);
      freev[w]  = in_use[w] & ~meta_row[w].valid;
    end
  end

  // lowest set bit
  assign hit_oh  = hitv & (~hitv + MAX_WAYS'(1));
  assign free_oh = freev & (~freev + MAX_WAYS'(1));

  // victim: oldest live line, lowest way on a tie
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vic_oh[w] = live[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v != w && live[v] &&
            (meta_row[v].age > meta_row[w].age ||
             (meta_row[v].age == meta_row[w].age && v < w))) begin
          vic_oh[w] = 1'b0;
        end
      end
    end
  end

  assign any_hit  = |hitv;
  assign any_free = |freev;
  assign target   = any_hit ? hit_oh : (any_free ? free_oh : vic_oh);

  always_comb begin
    ref_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (target[w]) begin
        ref_age = ref_age | meta_row[w].age;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_new[w] = meta_row[w];
      tag_new[w]  = tag_row[w];
      if (target[w]) begin
        meta_new[w].valid = 1'b1;
        meta_new[w].age   = '0;
        if (!any_hit) begin
          tag_new[w] = tag;
        end
      end else if (live[w] && ((!any_hit && any_free) || meta_row[w].age < ref_age)) begin
        if (meta_row[w].age != AGE_MAX) begin
          meta_new[w].age = meta_row[w].age + AGE_W'(1);
        end
      end
    end
    if (any_hit) begin
      outcome = OUT_HIT;
    end else if (any_free) begin
      outcome = OUT_MISS;
    end else begin
      outcome = OUT_EVICT;
    end
  end

endmodule
`default_nettype wire
